// ===== rtl/a64lrt_pkg.sv =====
`timescale 1ns / 1ps

package a64lrt_pkg;

  localparam int RegCount = 32;
  localparam int RegIdxW  = $clog2(RegCount);

  localparam logic [31:0] MovzMask    = 32'h7f80_0000;
  localparam logic [31:0] MovzMatch   = 32'h5280_0000;
  localparam logic [31:0] TopByteMask = 32'hff00_0000;
  localparam logic [31:0] LdrXMatch   = 32'h5800_0000;
  localparam logic [31:0] LdrWMatch   = 32'h1800_0000;
  localparam logic [31:0] LdrSwMatch  = 32'h9800_0000;
  localparam logic [31:0] AdrMask     = 32'h9f00_0000;
  localparam logic [31:0] AdrpMatch   = 32'h9000_0000;
  localparam logic [31:0] AdrMatch    = 32'h1000_0000;
  localparam logic [31:0] AddExtMask  = 32'h7fe0_0c00;
  localparam logic [31:0] AddExtMatch = 32'h0b20_0000;
  localparam logic [31:0] AddImmMask  = 32'h7f00_0000;
  localparam logic [31:0] AddImmMatch = 32'h1100_0000;

  localparam logic [4:0] AddExtRm      = 5'd15;
  localparam logic [1:0] AddImmShift12 = 2'b01;

  localparam logic CfgTargetOffset = 1'b0;
  localparam logic CfgImageSize    = 1'b1;

  typedef struct packed {
    logic               wr;
    logic               use_base;
    logic               chk;
    logic [RegIdxW-1:0] rd;
    logic [63:0]        opnd;
  } op_t;

endpackage

// ===== rtl/a64lrt_decode.sv =====
`timescale 1ns / 1ps

module a64lrt_decode
  import a64lrt_pkg::*;
(
  input  logic [31:0] instr_word_i,
  input  logic [63:0] offset_i,
  input  logic [63:0] literal_word_i,
  input  logic [31:0] image_size_i,
  output op_t         op_o
);

  logic [31:0] w;
  logic [4:0]  rd;
  logic [4:0]  rn;
  logic [31:0] top_byte;
  logic [34:0] ldr_t;
  logic        ldr_ok;
  logic [63:0] adrp_val;
  logic [63:0] adr_val;
  logic [63:0] addimm_val;

  assign w        = instr_word_i;
  assign rd       = w[4:0];
  assign rn       = w[9:5];
  assign top_byte = w & TopByteMask;

  assign ldr_t  = {3'b000, offset_i[31:0]} + {{14{w[23]}}, w[23:5], 2'b00};
  assign ldr_ok = !ldr_t[34] && ((ldr_t + 35'd4) <= {3'b000, image_size_i});

  assign adrp_val = {offset_i[63:12], 12'h000} +
                    {{31{w[23]}}, w[23:5], w[30:29], 12'h000};
  assign adr_val  = offset_i + {{43{w[23]}}, w[23:5], w[30:29]};

  assign addimm_val = (w[23:22] == AddImmShift12) ? {40'd0, w[21:10], 12'h000}
                                                  : {52'd0, w[21:10]};

  always_comb begin
    op_o          = '0;
    op_o.rd       = rd[RegIdxW-1:0];
    if ((w & MovzMask) == MovzMatch) begin
      op_o.wr   = 1'b1;
      op_o.opnd = {48'd0, w[20:5]};
    end else if (top_byte == LdrXMatch || top_byte == LdrWMatch ||
                 top_byte == LdrSwMatch) begin
      op_o.wr   = ldr_ok;
      op_o.opnd = literal_word_i;
    end else if ((w & AdrMask) == AdrpMatch) begin
      op_o.wr   = 1'b1;
      op_o.opnd = adrp_val;
    end else if ((w & AdrMask) == AdrMatch) begin
      op_o.chk  = 1'b1;
      op_o.opnd = adr_val;
    end else if ((w & AddExtMask) == AddExtMatch) begin
      if (w[20:16] == AddExtRm && rn == rd) begin
        op_o.wr       = 1'b1;
        op_o.use_base = 1'b1;
        op_o.chk      = 1'b1;
        op_o.opnd     = offset_i + 64'd4;
      end
    end else if ((w & AddImmMask) == AddImmMatch) begin
      if (rn == rd) begin
        op_o.wr       = 1'b1;
        op_o.use_base = 1'b1;
        op_o.chk      = 1'b1;
        op_o.opnd     = addimm_val;
      end
    end
  end

endmodule

// ===== rtl/a64lrt_regfile.sv =====
`timescale 1ns / 1ps

module a64lrt_regfile
  import a64lrt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [RegIdxW-1:0] rd_addr_i,
  input  logic               clr_i,
  input  logic               wr_en_i,
  input  logic [RegIdxW-1:0] wr_addr_i,
  input  logic [63:0]        wr_data_i,
  output logic [63:0]        rd_data_o
);

  logic [63:0]         mem [RegCount];
  logic [63:0]         rdata_q;
  logic [RegCount-1:0] valid_q;
  logic [RegCount-1:0] valid_d;
  logic                rvalid_q;
  logic                fwd_q;
  logic [63:0]         fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (clr_i) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i] && !clr_i;
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i) && !clr_i;
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rvalid_q ? rdata_q : 64'd0);

`ifndef SYNTH
  a_clear_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && clr_i |=> rd_data_o == 64'd0)
    else $error("Read after a clear did not return zero.");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !clr_i |=> valid_q[$past(wr_addr_i)])
    else $error("Written entry is not marked valid.");

  a_forward_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_en_i && !clr_i && rd_addr_i == wr_addr_i
    |=> rd_data_o == $past(wr_data_i))
    else $error("Read of an entry being written missed the new value.");
`endif

endmodule

// ===== rtl/aarch64_literal_reference_tracker.sv =====
`timescale 1ns / 1ps
// A result is offered once its instruction has passed the stage-1 register and the output register.
// Throughput: one instruction per cycle while the output is not stalled; each one
// reads one tracked register, may write it, and gets the previous write forwarded.
// Reset clears the pipeline, both configuration registers and the valid bit of
// every tracked register, so all of them read as zero; no clearing pass is needed.

module aarch64_literal_reference_tracker
  import a64lrt_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] instr_offset_i,
  input  logic [63:0] literal_word_i,
  input  logic        scan_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] hit_offset_o
);

  localparam int OffW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [31:0] OffMask = 32'((64'd1 << OffW) - 64'd1);

  logic [63:0] target_q;
  logic [31:0] image_size_q;

  logic        in_fire;
  logic        s1_go;
  logic        s1_fire;
  logic [63:0] offset;
  op_t         dec_op;

  logic        s1_valid_q;
  op_t         s1_op_q;
  logic [31:0] s1_offset_q;

  logic [63:0] base;
  logic [63:0] result;
  logic        hit;

  logic        out_valid_q;
  logic        hit_q;
  logic [31:0] hit_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      image_size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTargetOffset: target_q     <= cfg_wdata_i;
        CfgImageSize:    image_size_q <= cfg_wdata_i[31:0];
        default:         ;
      endcase
    end
  end

  assign s1_go      = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  assign offset = {32'd0, instr_offset_i & OffMask};

  a64lrt_decode u_decode (
    .instr_word_i   (instr_word_i),
    .offset_i       (offset),
    .literal_word_i (literal_word_i),
    .image_size_i   (image_size_q),
    .op_o           (dec_op)
  );

  a64lrt_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (dec_op.rd),
    .clr_i     (in_fire && scan_start_i),
    .wr_en_i   (s1_fire && s1_op_q.wr),
    .wr_addr_i (s1_op_q.rd),
    .wr_data_i (result),
    .rd_data_o (base)
  );

  assign result = s1_op_q.use_base ? (base + s1_op_q.opnd) : s1_op_q.opnd;
  assign hit    = s1_op_q.chk && (result == target_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= dec_op;
      s1_offset_q <= instr_offset_i;
    end
    if (s1_fire) begin
      hit_q        <= hit;
      hit_offset_q <= s1_offset_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign hit_offset_o = hit_offset_q;

endmodule
